>>> sv/nnsa_pkg.sv
// shared widths, register indexes and payload types of the scaling address generator
package nnsa_pkg;

  // coordinate and image size width
  localparam int unsigned CoordBits   = 12;
  // byte offset width of a result
  localparam int unsigned OffsetBits  = 26;
  // bytes per pixel register width
  localparam int unsigned PixBits     = 3;
  // configuration port widths
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = CoordBits;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgSrcWidth  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgSrcHeight = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgDstWidth  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgDstHeight = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgPixBytes  = 3'd4;

  // input request: one destination pixel
  typedef struct packed {
    logic [CoordBits-1:0] dst_x;
    logic [CoordBits-1:0] dst_y;
  } in_t;

  // result request
  typedef struct packed {
    logic [OffsetBits-1:0] src_offset;
    logic [OffsetBits-1:0] dst_offset;
    logic                  out_of_range;
  } out_t;

  // per-item data carried alongside the divider and offset stages
  typedef struct packed {
    logic [CoordBits-1:0] dx;
    logic [CoordBits-1:0] dy;
    logic                 oor;
  } side_t;

endpackage

>>> sv/nnsa_divider.sv
// pipelined restoring divider, one quotient bit per stage, for both axes at once
module nnsa_divider import nnsa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [2*CoordBits-1:0] num_x_i,
  input  logic [2*CoordBits-1:0] num_y_i,
  input  logic [CoordBits-1:0]   den_x_i,
  input  logic [CoordBits-1:0]   den_y_i,
  input  side_t                  side_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [CoordBits-1:0]   quo_x_o,
  output logic [CoordBits-1:0]   quo_y_o,
  output side_t                  side_o
);

  localparam int unsigned N = CoordBits;
  localparam int unsigned W = 2 * CoordBits;

  // one restoring step: upper half is the partial remainder, lower half
  // shifts dividend bits out at the top and quotient bits in at the bottom
  function automatic logic [W-1:0] div_step(input logic [W-1:0] w,
                                            input logic [N-1:0] d);
    logic [N:0]   t;
    logic         ge;
    logic [N:0]   r;
    t  = {w[W-1:N], w[N-1]};
    ge = (t >= {1'b0, d});
    r  = ge ? (t - {1'b0, d}) : t;
    return {r[N-1:0], w[N-2:0], ge};
  endfunction

  logic           vld_q  [N];
  logic [W-1:0]   wx_q   [N];
  logic [W-1:0]   wy_q   [N];
  side_t          side_q [N];

  logic           rdy    [N+1];
  logic           src_v  [N];
  logic [W-1:0]   src_x  [N];
  logic [W-1:0]   src_y  [N];
  side_t          src_s  [N];
  logic [W-1:0]   wx_d   [N];
  logic [W-1:0]   wy_d   [N];

  // stage sources and ready chain
  always_comb begin
    src_v[0] = valid_i;
    src_x[0] = num_x_i;
    src_y[0] = num_y_i;
    src_s[0] = side_i;
    for (int k = 1; k < N; k++) begin
      src_v[k] = vld_q[k-1];
      src_x[k] = wx_q[k-1];
      src_y[k] = wy_q[k-1];
      src_s[k] = side_q[k-1];
    end
    rdy[N] = ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 0; k < N; k++) begin
      wx_d[k] = div_step(src_x[k], den_x_i);
      wy_d[k] = div_step(src_y[k], den_y_i);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) vld_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) vld_q[k] <= src_v[k];
      end
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (rdy[k]) begin
        wx_q[k]   <= wx_d[k];
        wy_q[k]   <= wy_d[k];
        side_q[k] <= src_s[k];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[N-1];
  assign quo_x_o = wx_q[N-1][N-1:0];
  assign quo_y_o = wy_q[N-1][N-1:0];
  assign side_o  = side_q[N-1];

endmodule

>>> sv/nnsa_offset.sv
// row multiply, column add and pixel size multiply, ending in the output register
module nnsa_offset import nnsa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [CoordBits-1:0] quo_x_i,
  input  logic [CoordBits-1:0] quo_y_i,
  input  side_t                side_i,
  input  logic [CoordBits-1:0] src_width_i,
  input  logic [CoordBits-1:0] dst_width_i,
  input  logic [PixBits-1:0]   pixel_bytes_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output out_t                 data_o
);

  localparam int unsigned RW = 2 * CoordBits;
  localparam int unsigned SW = RW + 1;
  localparam int unsigned PW = SW + PixBits;
  localparam int unsigned WW = (PW > OffsetBits) ? PW : OffsetBits;

  // stage a: row times width
  logic                 a_vld_q;
  logic [RW-1:0]        a_rs_q;
  logic [RW-1:0]        a_rd_q;
  logic [CoordBits-1:0] a_sx_q;
  side_t                a_side_q;
  // stage b: plus column
  logic                 b_vld_q;
  logic [SW-1:0]        b_ls_q;
  logic [SW-1:0]        b_ld_q;
  logic                 b_oor_q;
  // stage c: output register
  logic                 c_vld_q;
  out_t                 c_data_q;
  out_t                 c_data_d;

  logic a_rdy, b_rdy, c_rdy;
  logic [PW-1:0] prod_s, prod_d;
  logic [WW-1:0] wide_s, wide_d;

  // ready chain
  assign c_rdy = !c_vld_q || ready_i;
  assign b_rdy = !b_vld_q || c_rdy;
  assign a_rdy = !a_vld_q || b_rdy;

  // pixel size multiply, wrapped to the offset width, zero outside the image
  always_comb begin
    prod_s = PW'(b_ls_q) * PW'(pixel_bytes_i);
    prod_d = PW'(b_ld_q) * PW'(pixel_bytes_i);
    wide_s = WW'(prod_s);
    wide_d = WW'(prod_d);
    c_data_d.out_of_range = b_oor_q;
    c_data_d.src_offset   = b_oor_q ? '0 : wide_s[OffsetBits-1:0];
    c_data_d.dst_offset   = b_oor_q ? '0 : wide_d[OffsetBits-1:0];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_rs_q   <= RW'(quo_y_i) * RW'(src_width_i);
      a_rd_q   <= RW'(side_i.dy) * RW'(dst_width_i);
      a_sx_q   <= quo_x_i;
      a_side_q <= side_i;
    end
    if (b_rdy) begin
      b_ls_q  <= SW'(a_rs_q) + SW'(a_sx_q);
      b_ld_q  <= SW'(a_rd_q) + SW'(a_side_q.dx);
      b_oor_q <= a_side_q.oor;
    end
    if (c_rdy) begin
      c_data_q <= c_data_d;
    end
  end

  assign ready_o = a_rdy;
  assign valid_o = c_vld_q;
  assign data_o  = c_data_q;

endmodule

>>> sv/nearest_neighbor_scale_addr.sv
// top level of the nearest-neighbor scaling address generator
//
// Input channel: in_valid_i / in_stall_o with one destination pixel (dst_x, dst_y)
// per request. Output channel: out_valid_o / out_stall_i with the source and
// destination byte offsets and an out-of-range flag, one result per input.
// A request moves when valid is high and stall is low.
// Configuration: cfg_valid_i / cfg_ready_o write port, index 0 source width,
// 1 source height, 2 destination width, 3 destination height, 4 bytes per
// pixel; other indexes are ignored. Write only while the pipeline is empty.
// Stages: one multiply stage, one divider stage per quotient bit, then row
// multiply, column add and pixel size multiply into the output register.
// Throughput is one pixel per cycle while the output is not stalled; every
// stage has its own valid bit.
// Reset empties the pipeline and sets all sizes to 1 and 4 bytes per pixel.
// A stalled receiver holds the output register; earlier stages keep filling
// bubbles and in_stall_o rises only once every stage holds a pixel.
module nearest_neighbor_scale_addr import nnsa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_t                    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_t                   out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int unsigned W = 2 * CoordBits;

  logic [CoordBits-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [PixBits-1:0]   pixel_bytes_q;

  logic          s1_vld_q;
  logic [W-1:0]  s1_px_q, s1_py_q;
  side_t         s1_side_q;
  side_t         s1_side_d;
  logic          s1_rdy;

  logic                 div_ready, div_valid, off_ready;
  logic [CoordBits-1:0] quo_x, quo_y;
  side_t                div_side;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= CoordBits'(1);
      src_height_q  <= CoordBits'(1);
      dst_width_q   <= CoordBits'(1);
      dst_height_q  <= CoordBits'(1);
      pixel_bytes_q <= PixBits'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSrcWidth:  src_width_q   <= cfg_data_i;
        CfgSrcHeight: src_height_q  <= cfg_data_i;
        CfgDstWidth:  dst_width_q   <= cfg_data_i;
        CfgDstHeight: dst_height_q  <= cfg_data_i;
        CfgPixBytes:  pixel_bytes_q <= cfg_data_i[PixBits-1:0];
        default: ;
      endcase
    end
  end

  // first stage: range check and scale multiplies
  assign s1_rdy     = !s1_vld_q || div_ready;
  assign in_stall_o = !s1_rdy;

  always_comb begin
    s1_side_d.dx  = in_data_i.dst_x;
    s1_side_d.dy  = in_data_i.dst_y;
    s1_side_d.oor = (in_data_i.dst_x >= dst_width_q) || (in_data_i.dst_y >= dst_height_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_px_q   <= W'(in_data_i.dst_x) * W'(src_width_q);
      s1_py_q   <= W'(in_data_i.dst_y) * W'(src_height_q);
      s1_side_q <= s1_side_d;
    end
  end

  // source coordinate divider
  nnsa_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_vld_q),
    .ready_o (div_ready),
    .num_x_i (s1_px_q),
    .num_y_i (s1_py_q),
    .den_x_i (dst_width_q),
    .den_y_i (dst_height_q),
    .side_i  (s1_side_q),
    .valid_o (div_valid),
    .ready_i (off_ready),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .side_o  (div_side)
  );

  // byte offset stages
  nnsa_offset u_off (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (div_valid),
    .ready_o       (off_ready),
    .quo_x_i       (quo_x),
    .quo_y_i       (quo_y),
    .side_i        (div_side),
    .src_width_i   (src_width_q),
    .dst_width_i   (dst_width_q),
    .pixel_bytes_i (pixel_bytes_q),
    .valid_o       (out_valid_o),
    .ready_i       (!out_stall_i),
    .data_o        (out_data_o)
  );

  // a pixel outside the destination never carries an offset
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_of_range
      |-> out_data_o.src_offset == '0 && out_data_o.dst_offset == '0)
    else $error("out-of-range result with nonzero offset");

  // a draining output lets the whole pipeline move
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  // zero bytes per pixel gives zero offsets
  a_zero_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_bytes_q == '0
      |-> out_data_o.src_offset == '0 && out_data_o.dst_offset == '0)
    else $error("nonzero offset with zero pixel size");

endmodule
